[sv/dss_pkg.sv]
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and constants for the two-stack shared-store block.
// ----------------------------------------------------------------------------
package dss_pkg;

  localparam int unsigned DefaultDepth = 8;
  localparam int unsigned WordW        = 32;
  localparam int unsigned SizeW        = 4;
  localparam int unsigned CmdW         = 3;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH_A = 3'd0,
    CMD_PUSH_B = 3'd1,
    CMD_POP_A  = 3'd2,
    CMD_POP_B  = 3'd3,
    CMD_PEEK_A = 3'd4,
    CMD_PEEK_B = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

endpackage

[sv/dual_stack_shared_memory_top.sv]
// ----------------------------------------------------------------------------
// dual_stack_shared_memory_top
// Two stacks in one shared store: A grows up from entry 0, B down from the top.
// ----------------------------------------------------------------------------
// One request per clock while results are taken; each result appears in the
// cycle after its request is accepted, from the registered read of the
// single-port store. A stalled result holds the input side. The store needs
// no clearing after reset.
module dual_stack_shared_memory_top import dss_pkg::*; #(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [CmdW-1:0]         command_i,
  input  logic signed [WordW-1:0] push_value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [WordW-1:0] read_value_o,
  output logic [1:0]              status_o,
  output logic [SizeW-1:0]        size_a_o,
  output logic [SizeW-1:0]        size_b_o
);

  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                    mem_we;
  logic                    mem_re;
  logic [AddrW-1:0]        mem_addr;
  logic signed [WordW-1:0] mem_wdata;
  logic signed [WordW-1:0] mem_rdata;

  dss_ctrl #(.Depth(DEPTH)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .push_value_i (push_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .size_a_o     (size_a_o),
    .size_b_o     (size_b_o),
    .mem_we_o     (mem_we),
    .mem_re_o     (mem_re),
    .mem_addr_o   (mem_addr),
    .mem_wdata_o  (mem_wdata),
    .mem_rdata_i  (mem_rdata)
  );

  dss_mem #(.Depth(DEPTH)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule

[sv/dss_mem.sv]
// ----------------------------------------------------------------------------
// dss_mem
// Single-port synchronous store shared by both stacks, registered read.
// ----------------------------------------------------------------------------
module dss_mem import dss_pkg::*; #(
  parameter int unsigned Depth = DefaultDepth,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic                    re_i,
  input  logic [AddrW-1:0]        addr_i,
  input  logic signed [WordW-1:0] wdata_i,
  output logic signed [WordW-1:0] rdata_o
);

  logic signed [WordW-1:0] mem_q [Depth];
  logic signed [WordW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/dss_ctrl.sv]
// ----------------------------------------------------------------------------
// dss_ctrl
// Stack pointers, command decode, store access and result register.
// ----------------------------------------------------------------------------
module dss_ctrl import dss_pkg::*; #(
  parameter int unsigned Depth = DefaultDepth,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CntW  = $clog2(Depth + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [CmdW-1:0]         command_i,
  input  logic signed [WordW-1:0] push_value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [WordW-1:0] read_value_o,
  output logic [1:0]              status_o,
  output logic [SizeW-1:0]        size_a_o,
  output logic [SizeW-1:0]        size_b_o,
  output logic                    mem_we_o,
  output logic                    mem_re_o,
  output logic [AddrW-1:0]        mem_addr_o,
  output logic signed [WordW-1:0] mem_wdata_o,
  input  logic signed [WordW-1:0] mem_rdata_i
);

  logic            accept;
  logic            full;
  logic [CntW:0]   total;
  logic [CntW-1:0] cnt_a_q, cnt_a_d;
  logic [CntW-1:0] cnt_b_q, cnt_b_d;
  logic [CntW-1:0] push_b_idx, top_a_idx, top_b_idx;
  logic            out_valid_q;
  status_e         status_q, status_d;
  logic            take_mem_q, take_mem_d;
  logic [SizeW-1:0] size_a_q, size_b_q;
  logic            we, re;
  logic [AddrW-1:0] addr;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign total      = {1'b0, cnt_a_q} + {1'b0, cnt_b_q};
  assign full       = total >= (CntW+1)'(Depth);
  assign push_b_idx = CntW'(Depth - 1) - cnt_b_q;
  assign top_a_idx  = cnt_a_q - CntW'(1);
  assign top_b_idx  = CntW'(Depth) - cnt_b_q;

  always_comb begin
    cnt_a_d    = cnt_a_q;
    cnt_b_d    = cnt_b_q;
    status_d   = ST_OK;
    take_mem_d = 1'b0;
    we         = 1'b0;
    re         = 1'b0;
    addr       = '0;
    case (cmd_e'(command_i))
      CMD_PUSH_A: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          we      = 1'b1;
          addr    = cnt_a_q[AddrW-1:0];
          cnt_a_d = cnt_a_q + CntW'(1);
        end
      end
      CMD_PUSH_B: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          we      = 1'b1;
          addr    = push_b_idx[AddrW-1:0];
          cnt_b_d = cnt_b_q + CntW'(1);
        end
      end
      CMD_POP_A, CMD_PEEK_A: begin
        if (cnt_a_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          re         = 1'b1;
          take_mem_d = 1'b1;
          addr       = top_a_idx[AddrW-1:0];
          if (cmd_e'(command_i) == CMD_POP_A) begin
            cnt_a_d = top_a_idx;
          end
        end
      end
      CMD_POP_B, CMD_PEEK_B: begin
        if (cnt_b_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          re         = 1'b1;
          take_mem_d = 1'b1;
          addr       = top_b_idx[AddrW-1:0];
          if (cmd_e'(command_i) == CMD_POP_B) begin
            cnt_b_d = cnt_b_q - CntW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign mem_we_o    = accept && we;
  assign mem_re_o    = accept && re;
  assign mem_addr_o  = addr;
  assign mem_wdata_o = push_value_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_a_q     <= cnt_a_d;
        cnt_b_q     <= cnt_b_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q   <= status_d;
      take_mem_q <= take_mem_d;
      size_a_q   <= SizeW'(cnt_a_d);
      size_b_q   <= SizeW'(cnt_b_d);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign size_a_o     = size_a_q;
  assign size_b_o     = size_b_q;
  assign read_value_o = take_mem_q ? mem_rdata_i :
                        ((status_q == ST_EMPTY) ? '1 : '0);

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total <= (CntW+1)'(Depth))
    else $error("stacks overlap");

  a_full_means_met: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (status_d == ST_FULL) |=> total == (CntW+1)'(Depth))
    else $error("push refused while space remains");

  a_empty_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q == ST_EMPTY) |-> (size_a_q == '0) || (size_b_q == '0))
    else $error("empty status with both stacks occupied");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(read_value_o)
      && $stable(size_a_q) && $stable(size_b_q))
    else $error("stalled result changed");

endmodule

[tb/dual_stack_shared_memory_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_stack_shared_memory_top_tb
// Checks the two-stack shared store against its own model of both stacks.
// A table of directed requests comes first (empty stacks, unused codes, word
// extremes, the stacks meeting), then random request sequences biased towards
// filling or draining either stack. Both sides idle at random, the result side
// holds off once for a long stretch, and every result is compared field by
// field with the oldest expectation.
// ----------------------------------------------------------------------------
module dual_stack_shared_memory_top_tb;
  import dss_pkg::*;

  localparam int unsigned DEPTH         = DefaultDepth;
  localparam int unsigned RandomItems   = 1325;
  localparam int unsigned HoldOffAt     = 600;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned IdleLimit     = 2000;

  localparam logic [CmdW-1:0]  CmdUnused6 = 3'd6;
  localparam logic [CmdW-1:0]  CmdUnused7 = 3'd7;
  localparam logic [WordW-1:0] EmptyWord  = '1;

  typedef struct packed {
    logic [WordW-1:0] read_value;
    status_e          status;
    logic [SizeW-1:0] size_a;
    logic [SizeW-1:0] size_b;
  } stack_result_t;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [WordW-1:0] value;
    bit               typed;
    stack_result_t    result;
  } dir_row_t;

  localparam stack_result_t Predicted = '{32'h0, ST_OK, 4'd0, 4'd0};

  localparam dir_row_t DirTable [25] = '{
    '{CMD_POP_A,  32'h0000_0000, 1'b1, '{EmptyWord, ST_EMPTY, 4'd0, 4'd0}},
    '{CMD_POP_B,  32'h0000_0000, 1'b1, '{EmptyWord, ST_EMPTY, 4'd0, 4'd0}},
    '{CMD_PEEK_A, 32'h0000_0000, 1'b1, '{EmptyWord, ST_EMPTY, 4'd0, 4'd0}},
    '{CMD_PEEK_B, 32'hFFFF_FFFF, 1'b1, '{EmptyWord, ST_EMPTY, 4'd0, 4'd0}},
    '{CmdUnused6, 32'h1234_5678, 1'b1, '{32'h0, ST_OK, 4'd0, 4'd0}},
    '{CmdUnused7, 32'h0000_0000, 1'b1, '{32'h0, ST_OK, 4'd0, 4'd0}},
    '{CMD_PUSH_A, 32'h7FFF_FFFF, 1'b1, '{32'h0, ST_OK, 4'd1, 4'd0}},
    '{CMD_PUSH_B, 32'h8000_0000, 1'b1, '{32'h0, ST_OK, 4'd1, 4'd1}},
    '{CMD_PEEK_A, 32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, ST_OK, 4'd1, 4'd1}},
    '{CMD_PEEK_B, 32'h0000_0000, 1'b1, '{32'h8000_0000, ST_OK, 4'd1, 4'd1}},
    '{CMD_PUSH_A, 32'hFFFF_FFFF, 1'b0, Predicted},
    '{CMD_PUSH_A, 32'h0000_0000, 1'b0, Predicted},
    '{CMD_PUSH_B, 32'h5555_5555, 1'b0, Predicted},
    '{CMD_PUSH_A, 32'hAAAA_AAAA, 1'b0, Predicted},
    '{CMD_PUSH_B, 32'h0000_0001, 1'b0, Predicted},
    '{CMD_PUSH_B, 32'hFFFF_FFFE, 1'b0, Predicted},
    '{CMD_PUSH_A, 32'h0000_0001, 1'b1, '{32'h0, ST_FULL, 4'd4, 4'd4}},
    '{CMD_PUSH_B, 32'h0000_0001, 1'b1, '{32'h0, ST_FULL, 4'd4, 4'd4}},
    '{CMD_PEEK_B, 32'h0000_0000, 1'b0, Predicted},
    '{CMD_POP_A,  32'h0000_0000, 1'b0, Predicted},
    '{CMD_POP_B,  32'h0000_0000, 1'b0, Predicted},
    '{CMD_PUSH_B, 32'h0000_0003, 1'b0, Predicted},
    '{CMD_PUSH_A, 32'hDEAD_BEEF, 1'b0, Predicted},
    '{CMD_POP_A,  32'h0000_0000, 1'b0, Predicted},
    '{CmdUnused7, 32'hFFFF_FFFF, 1'b0, Predicted}
  };

  logic                    clk          = 1'b0;
  logic                    rst_n        = 1'b0;
  logic                    in_valid     = 1'b0;
  logic [CmdW-1:0]         command      = '0;
  logic signed [WordW-1:0] push_value   = '0;
  logic                    out_stall    = 1'b0;
  bit                      req_typed    = 1'b0;
  stack_result_t           req_expected = Predicted;

  logic                    in_stall_o;
  logic                    out_valid_o;
  logic signed [WordW-1:0] read_value_o;
  logic [1:0]              status_o;
  logic [SizeW-1:0]        size_a_o;
  logic [SizeW-1:0]        size_b_o;

  logic [WordW-1:0] store_words [DEPTH];
  int unsigned      fill_a       = 0;
  int unsigned      fill_b       = 0;
  stack_result_t    pending_results [$];
  int unsigned      mismatch_count = 0;
  int unsigned      idle_cycles    = 0;
  bit               sender_quiet   = 1'b0;

  dual_stack_shared_memory_top #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .command_i   (command),
    .push_value_i(push_value),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .read_value_o(read_value_o),
    .status_o    (status_o),
    .size_a_o    (size_a_o),
    .size_b_o    (size_b_o)
  );

  always #5 clk = ~clk;

  function automatic stack_result_t stack_step(logic [CmdW-1:0] cmd, logic [WordW-1:0] value);
    stack_result_t r;
    bit            full;
    r.read_value = '0;
    r.status     = ST_OK;
    full         = (fill_a + fill_b) >= DEPTH;
    case (cmd)
      CMD_PUSH_A: begin
        if (full) begin
          r.status = ST_FULL;
        end else begin
          store_words[fill_a] = value;
          fill_a++;
        end
      end
      CMD_PUSH_B: begin
        if (full) begin
          r.status = ST_FULL;
        end else begin
          fill_b++;
          store_words[DEPTH - fill_b] = value;
        end
      end
      CMD_POP_A, CMD_PEEK_A: begin
        if (fill_a == 0) begin
          r.read_value = EmptyWord;
          r.status     = ST_EMPTY;
        end else begin
          r.read_value = store_words[fill_a - 1];
          if (cmd == CMD_POP_A) fill_a--;
        end
      end
      CMD_POP_B, CMD_PEEK_B: begin
        if (fill_b == 0) begin
          r.read_value = EmptyWord;
          r.status     = ST_EMPTY;
        end else begin
          r.read_value = store_words[DEPTH - fill_b];
          if (cmd == CMD_POP_B) fill_b--;
        end
      end
      default: ;
    endcase
    r.size_a = SizeW'(fill_a);
    r.size_b = SizeW'(fill_b);
    return r;
  endfunction

  // results first, then the request taken at the same edge
  always @(posedge clk) begin
    stack_result_t predicted;
    stack_result_t want;
    if (rst_n) begin
      if (out_valid_o && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding");
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (read_value_o !== want.read_value) begin
            $error("read_value: expected %0h, got %0h", want.read_value, read_value_o);
            mismatch_count++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            mismatch_count++;
          end
          if (size_a_o !== want.size_a) begin
            $error("size_a: expected %0d, got %0d", want.size_a, size_a_o);
            mismatch_count++;
          end
          if (size_b_o !== want.size_b) begin
            $error("size_b: expected %0d, got %0d", want.size_b, size_b_o);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall_o) begin
        predicted = stack_step(command, push_value);
        pending_results.push_back(req_typed ? req_expected : predicted);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(logic [CmdW-1:0] cmd, logic [WordW-1:0] value, bit typed,
                              stack_result_t result);
    int unsigned gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    push_value   <= value;
    req_typed    <= typed;
    req_expected <= result;
    do @(posedge clk); while (in_stall_o);
  endtask

  initial begin : receiver
    int unsigned hold;
    int unsigned taken;
    bit          quiet;
    taken = 0;
    quiet = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (taken % 32 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (taken == HoldOffAt) hold = HoldOffCycles;
      else hold = quiet ? 0 : $urandom_range(0, 19);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid_o);
      taken++;
    end
  end

  initial begin : sender
    int unsigned      counted;
    int unsigned      issued;
    int unsigned      bias;
    int unsigned      push_pct;
    int unsigned      a_pct;
    int unsigned      pick;
    logic [CmdW-1:0]  cmd;
    logic [WordW-1:0] value;
    counted  = 0;
    issued   = 0;
    push_pct = 50;
    a_pct    = 50;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DirTable[i]) begin
      send_request(DirTable[i].cmd, DirTable[i].value, DirTable[i].typed, DirTable[i].result);
    end

    // sequences lean towards filling, draining, or one side, so both full and empty recur
    while (counted < RandomItems) begin
      if (issued % 48 == 0) begin
        sender_quiet = ($urandom_range(0, 3) == 0);
        bias         = $urandom_range(0, 3);
        case (bias)
          0: begin push_pct = 75; a_pct = 50; end
          1: begin push_pct = 25; a_pct = 50; end
          2: begin push_pct = 55; a_pct = 90; end
          default: begin push_pct = 55; a_pct = 10; end
        endcase
      end
      issued++;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        cmd = $urandom_range(0, 1) ? CmdUnused7 : CmdUnused6;
      end else if ($urandom_range(0, 99) < push_pct) begin
        cmd = ($urandom_range(0, 99) < a_pct) ? CMD_PUSH_A : CMD_PUSH_B;
      end else if ($urandom_range(0, 99) < a_pct) begin
        cmd = $urandom_range(0, 2) != 0 ? CMD_POP_A : CMD_PEEK_A;
      end else begin
        cmd = $urandom_range(0, 2) != 0 ? CMD_POP_B : CMD_PEEK_B;
      end
      case ($urandom_range(0, 15))
        0:       value = 32'h0000_0000;
        1:       value = 32'h7FFF_FFFF;
        2:       value = 32'h8000_0000;
        3:       value = 32'hFFFF_FFFF;
        default: value = $urandom;
      endcase
      send_request(cmd, value, 1'b0, Predicted);
      if (cmd != CmdUnused6 && cmd != CmdUnused7) counted++;
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
sv/dss_pkg.sv
sv/dss_mem.sv
sv/dss_ctrl.sv
sv/dual_stack_shared_memory_top.sv
tb/dual_stack_shared_memory_top_tb.sv
